// ===== design/atan2_pkg.sv =====
// ----------------------------------------------------------------------------
// atan2_pkg
// Constants for the pipelined four-quadrant arctangent.
// ----------------------------------------------------------------------------
package atan2_pkg;

  localparam int RatioW = 16;
  localparam int AccW   = 19;
  localparam int NumCoef = 7;

  localparam logic signed [AccW-1:0] HornerCoef [NumCoef] = '{
    19'sd945, -19'sd4595, 19'sd10705, -19'sd17530,
    19'sd26026, -19'sd43680, 19'sd131072
  };

  localparam logic signed [23:0] Q20Pi     = 24'sd3294199;
  localparam logic signed [23:0] Q20HalfPi = 24'sd1647099;
  localparam logic [15:0]        AngleMax  = 16'd25736;

endpackage

// ===== design/atan2_polynomial_approx_top.sv =====
// ----------------------------------------------------------------------------
// atan2_polynomial_approx_top
// Four-quadrant arctangent: restoring-divider ratio, Horner polynomial, fold.
// ----------------------------------------------------------------------------
// Pipeline: one input stage, one divider stage per quotient bit for 17
//   bits, two for the square, two per Horner step (12 in all), and four
//   to scale, fold and round.
// Throughput: one item per cycle; busy is always low, no stall exists.
// Reset: rst_ni clears all valid bits asynchronously; payload is not reset.
module atan2_polynomial_approx_top #(
  parameter int IN_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] y_value_i,
  input  logic signed [15:0] x_value_i,
  output logic               done_o,
  output logic signed [15:0] angle_o
);
  import atan2_pkg::*;

  localparam int MagW  = IN_WIDTH;          // magnitude incl. 2^(W-1)
  localparam int DivSt = RatioW + 1;        // quotient bits incl. overflow bit
  localparam int RemW  = MagW + 1;
  localparam int HSt   = 2 * (NumCoef - 1); // stages, in multiply / round-add pairs

  typedef struct packed {
    logic y_big;
    logic x_neg;
    logic y_neg;
    logic zero;
  } flags_t;

  assign busy = 1'b0;

  // ---- stage 0: input slice, magnitudes, order ----
  logic signed [IN_WIDTH-1:0] y_s, x_s;
  logic [MagW-1:0] ay, ax;
  assign y_s = y_value_i[IN_WIDTH-1:0];
  assign x_s = x_value_i[IN_WIDTH-1:0];
  assign ay  = y_s[IN_WIDTH-1] ? MagW'(-y_s) : MagW'(y_s);
  assign ax  = x_s[IN_WIDTH-1] ? MagW'(-x_s) : MagW'(x_s);

  logic            v0_q;
  flags_t          f0_q;
  logic [MagW-1:0] big0_q, small0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else         v0_q <= start;
  end
  always_ff @(posedge clk_i) begin
    f0_q.y_big <= ay > ax;
    f0_q.x_neg <= x_s[IN_WIDTH-1];
    f0_q.y_neg <= y_s[IN_WIDTH-1];
    f0_q.zero  <= (ay == '0) && (ax == '0);
    big0_q     <= (ay > ax) ? ay : ax;
    small0_q   <= (ay > ax) ? ax : ay;
  end

  // ---- divider: one quotient bit per stage, MSB (2^16 weight) first ----
  logic              dv_q  [DivSt+1];
  flags_t            df_q  [DivSt+1];
  logic [RemW-1:0]   rem_q [DivSt+1];
  logic [MagW-1:0]   den_q [DivSt+1];
  logic [DivSt-1:0]  quo_q [DivSt+1];

  always_comb begin
    dv_q[0]  = v0_q;
    df_q[0]  = f0_q;
    rem_q[0] = RemW'(small0_q);
    den_q[0] = big0_q;
    quo_q[0] = '0;
  end

  for (genvar g = 0; g < DivSt; g++) begin : g_div
    logic [RemW:0] trial;
    logic          ge;
    // remainder < den at entry, so doubling fits RemW+1 bits
    assign trial = {rem_q[g], 1'b0};
    assign ge    = (g == 0) ? (rem_q[g] >= RemW'(den_q[g]))
                            : (trial >= (RemW+1)'(den_q[g]));
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[g+1] <= 1'b0;
      else         dv_q[g+1] <= dv_q[g];
    end
    always_ff @(posedge clk_i) begin
      df_q[g+1]  <= df_q[g];
      den_q[g+1] <= den_q[g];
      quo_q[g+1] <= {quo_q[g][DivSt-2:0], ge};
      if (g == 0)
        rem_q[g+1] <= ge ? rem_q[g] - RemW'(den_q[g]) : rem_q[g];
      else
        rem_q[g+1] <= ge ? RemW'(trial - (RemW+1)'(den_q[g])) : RemW'(trial);
    end
  end

  // ---- ratio saturate and square ----
  logic [RatioW-1:0] r_d;
  assign r_d = quo_q[DivSt][DivSt-1] ? {RatioW{1'b1}} : quo_q[DivSt][RatioW-1:0];

  logic              sv1_q, sv2_q;
  flags_t            sf1_q, sf2_q;
  logic [RatioW-1:0] sr1_q, sr2_q, s2_q;
  logic [2*RatioW-1:0] sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv1_q <= 1'b0;
      sv2_q <= 1'b0;
    end else begin
      sv1_q <= dv_q[DivSt];
      sv2_q <= sv1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    sf1_q <= df_q[DivSt];
    sr1_q <= r_d;
    sq_q  <= r_d * r_d;
    sf2_q <= sf1_q;
    sr2_q <= sr1_q;
    s2_q  <= RatioW'((sq_q + 32'd32768) >> 16);
  end

  // ---- Horner: even stage multiplies, odd stage rounds and adds ----
  logic                    hv_q [HSt+1];
  flags_t                  hf_q [HSt+1];
  logic [RatioW-1:0]       hr_q [HSt+1];
  logic [RatioW-1:0]       hs_q [HSt+1];
  logic signed [AccW-1:0]  ha_q [HSt+1];
  logic signed [AccW+RatioW:0] hp_q [HSt+1];

  always_comb begin
    hv_q[0] = sv2_q;
    hf_q[0] = sf2_q;
    hr_q[0] = sr2_q;
    hs_q[0] = s2_q;
    ha_q[0] = HornerCoef[0];
    hp_q[0] = '0;
  end

  for (genvar h = 0; h < HSt; h++) begin : g_horner
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) hv_q[h+1] <= 1'b0;
      else         hv_q[h+1] <= hv_q[h];
    end
    always_ff @(posedge clk_i) begin
      hf_q[h+1] <= hf_q[h];
      hr_q[h+1] <= hr_q[h];
      hs_q[h+1] <= hs_q[h];
      if (h % 2 == 0) begin
        hp_q[h+1] <= ha_q[h] * $signed({1'b0, hs_q[h]});
        ha_q[h+1] <= ha_q[h];
      end else begin
        hp_q[h+1] <= hp_q[h];
        ha_q[h+1] <= AccW'((hp_q[h] + 36'sd32768) >>> 16)
                     + HornerCoef[h/2 + 1];
      end
    end
  end

  // ---- base angle, reflections, rounding ----
  logic   tv1_q, tv2_q, tv3_q, done_q;
  flags_t tf1_q, tf2_q, tf3_q;
  logic signed [AccW+RatioW:0] tp_q;
  logic signed [23:0] t2_q, t3_q;
  logic signed [15:0] ang_q;
  logic signed [23:0] t_base, t_ref;
  logic [15:0] mag;

  assign t_base = 24'((tp_q + 36'sd4096) >>> 13);
  assign t_ref  = tf2_q.y_big ? Q20HalfPi - t2_q : t2_q;

  always_comb begin
    logic signed [23:0] t;
    logic [16:0] m;
    t   = tf3_q.x_neg ? Q20Pi - t3_q : t3_q;
    if (t < 0) t = '0;
    m   = 17'((t + 24'sd64) >>> 7);
    mag = (m > 17'(AngleMax)) ? AngleMax : m[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv1_q  <= 1'b0;
      tv2_q  <= 1'b0;
      tv3_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      tv1_q  <= hv_q[HSt];
      tv2_q  <= tv1_q;
      tv3_q  <= tv2_q;
      done_q <= tv3_q;
    end
  end
  always_ff @(posedge clk_i) begin
    tf1_q <= hf_q[HSt];
    tp_q  <= ha_q[HSt] * $signed({1'b0, hr_q[HSt]});
    tf2_q <= tf1_q;
    t2_q  <= t_base;
    tf3_q <= tf2_q;
    t3_q  <= t_ref;
    if (tf3_q.zero)       ang_q <= '0;
    else if (tf3_q.y_neg) ang_q <= -$signed(mag);
    else                  ang_q <= $signed(mag);
  end

  assign done_o  = done_q;
  assign angle_o = ang_q;

  // ---- assertions ----
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (angle_o <= 16'sd25736 && angle_o >= -16'sd25736))
    else $error("angle out of range");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tv3_q && tf3_q.zero |=> done_o && angle_o == '0)
    else $error("zero input not mapped to zero angle");
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[DivSt] |-> rem_q[DivSt] < RemW'(den_q[DivSt]) || den_q[DivSt] == '0)
    else $error("divider remainder not reduced");
endmodule
